FILE: rtl/occ_pkg.sv
package occ_pkg;

  localparam int MaxBoxesDefault = 32;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] REG_MOVER_HALF_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MOVER_HALF_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MOVER_COS    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MOVER_SIN    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OBST_COUNT   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SEP_MARGIN   = 3'd5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic KIND_LOAD_ACK = 1'b0;
  localparam logic KIND_QUERY    = 1'b1;

  // corner sign patterns, bit k set means that corner uses -1
  localparam logic [3:0] CORNER_SX_NEG = 4'b1100;
  localparam logic [3:0] CORNER_SY_NEG = 4'b1010;

  localparam int CornerW = 36;
  localparam int ProjW   = 56;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        hx;
    logic [30:0]        hy;
    logic signed [15:0] c;
    logic signed [15:0] s;
  } box_t;

endpackage

FILE: rtl/obb_collision_checker_core.sv
// oriented box collision checker, 2d separating-axis test
// input stream s_axis: tuser is the operation (0 load, 1 query), tdata holds
// the slot, center, half extents and cos/sin of a load, or the mover center
// of a query. configuration writes set the mover box, obstacle count and
// separation margin; write them only while the block is idle.
// output stream m_axis: one transfer per input item, tuser is the kind
// (0 load ack, 1 query answer), tdata bit 0 is blocked.
// a load writes one cell of the box chain and is acknowledged in the
// following cycle. a query rotates the whole chain of MAX_BOXES cells past a
// shared pair-test unit; each box in use is tested while nothing has hit yet:
// a start step, 8 corners of a multiply step and an add step, then 4 axes of
// 8 projections of a multiply step and a min/max step, each axis ending in a
// check that ends the test early when the axis separates. a box not tested
// is rotated past without a test.
// one item is in work at a time; the next item is taken once the block is
// idle and the output register is empty or being read in that cycle.
// when the receiver stalls, the result is held and a finished query waits.
// reset clears the control state and the registers to their reset values; the
// box table is undefined until loaded.
module obb_collision_checker_core #(
  parameter int MAX_BOXES = occ_pkg::MaxBoxesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [occ_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [occ_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // slot[4:0], pos_x[36:5], pos_y[68:37], half_x[99:69], half_y[130:100],
  // cos_angle[146:131], sin_angle[162:147], zero fill
  input  logic [167:0]                  s_axis_tdata,
  // operation
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // blocked, zero fill
  output logic [7:0]                    m_axis_tdata,
  // kind
  output logic                          m_axis_tuser
);
  import occ_pkg::*;

  localparam int IdxW = $clog2(MAX_BOXES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_QRY  = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic started_q, started_d;
  logic hit_q, hit_d;

  logic [30:0] mhx_q, mhy_q;
  logic signed [15:0] mcos_q, msin_q;
  logic [5:0] count_q;
  logic [15:0] margin_q;
  logic signed [31:0] qx_q, qy_q;

  logic out_valid_q, out_valid_d, out_kind_q, out_kind_d, out_blk_q, out_blk_d;

  box_t in_box, mover, cells [MAX_BOXES];
  logic [4:0] in_slot;
  logic in_acc, out_free, rotate, sat_start, sat_done, sat_ov, test_now;

  assign in_slot   = s_axis_tdata[4:0];
  assign in_box.cx = s_axis_tdata[36:5];
  assign in_box.cy = s_axis_tdata[68:37];
  assign in_box.hx = s_axis_tdata[99:69];
  assign in_box.hy = s_axis_tdata[130:100];
  assign in_box.c  = s_axis_tdata[146:131];
  assign in_box.s  = s_axis_tdata[162:147];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign mover.cx = qx_q;
  assign mover.cy = qy_q;
  assign mover.hx = mhx_q;
  assign mover.hy = mhy_q;
  assign mover.c  = mcos_q;
  assign mover.s  = msin_q;

  // box chain, cell 0 feeds the pair test, rotation brings cell i+1 to cell i
  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    occ_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (in_acc && s_axis_tuser == OP_LOAD && 32'(in_slot) == g),
      .load_box_i (in_box),
      .shift_i    (rotate),
      .nbr_box_i  (cells[(g + 1) % MAX_BOXES]),
      .box_o      (cells[g])
    );
  end

  occ_sat u_sat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sat_start),
    .mover_i   (mover),
    .box_i     (cells[0]),
    .margin_i  (margin_q),
    .done_o    (sat_done),
    .overlap_o (sat_ov)
  );

  // box at head is tested when it is in use and nothing has hit yet
  assign test_now = (32'(idx_q) < 32'(count_q)) && !hit_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    started_d   = started_q;
    hit_d       = hit_q;
    rotate      = 1'b0;
    sat_start   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_blk_d   = out_blk_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == OP_LOAD) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_LOAD_ACK;
            out_blk_d   = 1'b0;
          end else begin
            state_d   = ST_QRY;
            idx_d     = '0;
            hit_d     = 1'b0;
            started_d = 1'b0;
          end
        end
      end
      ST_QRY: begin
        if (32'(idx_q) >= 32'(MAX_BOXES)) begin
          state_d = ST_RES;
        end else if (test_now) begin
          if (!started_q) begin
            sat_start = 1'b1;
            started_d = 1'b1;
          end else if (sat_done) begin
            hit_d     = sat_ov;
            started_d = 1'b0;
            rotate    = 1'b1;
            idx_d     = idx_q + IdxW'(1);
          end
        end else begin
          rotate = 1'b1;
          idx_d  = idx_q + IdxW'(1);
        end
      end
      default: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_QUERY;
          out_blk_d   = hit_q;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      started_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mhx_q       <= '0;
      mhy_q       <= '0;
      mcos_q      <= 16'sd16384;
      msin_q      <= '0;
      count_q     <= '0;
      margin_q    <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      started_q   <= started_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MOVER_HALF_X: mhx_q    <= cfg_data_i;
          REG_MOVER_HALF_Y: mhy_q    <= cfg_data_i;
          REG_MOVER_COS:    mcos_q   <= cfg_data_i[15:0];
          REG_MOVER_SIN:    msin_q   <= cfg_data_i[15:0];
          REG_OBST_COUNT:   count_q  <= cfg_data_i[5:0];
          REG_SEP_MARGIN:   margin_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_blk_q  <= out_blk_d;
    if (in_acc) begin
      qx_q <= in_box.cx;
      qy_q <= in_box.cy;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {7'd0, out_blk_q};

`ifndef SYNTHESIS
  a_start_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_start |-> state_q == ST_QRY)
    else $error("pair test started outside a query");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) <= 32'(MAX_BOXES))
    else $error("chain position past table");
  a_load_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser == OP_LOAD |=> m_axis_tvalid && m_axis_tuser == KIND_LOAD_ACK)
    else $error("load not acknowledged");
  a_no_rotate_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q && !sat_done |-> !rotate)
    else $error("chain rotated during a pair test");
`endif

endmodule

FILE: rtl/occ_cell.sv
module occ_cell (
  input  logic          clk_i,
  input  logic          load_i,
  input  occ_pkg::box_t load_box_i,
  input  logic          shift_i,
  input  occ_pkg::box_t nbr_box_i,
  output occ_pkg::box_t box_o
);
  import occ_pkg::*;

  box_t box_q, box_d;

  always_comb begin
    box_d = box_q;
    if (load_i) begin
      box_d = load_box_i;
    end else if (shift_i) begin
      box_d = nbr_box_i;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign box_o = box_q;

endmodule

FILE: rtl/occ_sat.sv
module occ_sat (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  occ_pkg::box_t mover_i,
  input  occ_pkg::box_t box_i,
  input  logic [15:0]   margin_i,
  output logic          done_o,
  output logic          overlap_o
);
  import occ_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CORN = 2'd1;
  localparam logic [1:0] S_PROJ = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] k_q, k_d;
  logic       sub_q, sub_d;
  logic [1:0] ax_q, ax_d;

  logic signed [CornerW-1:0] xs_q [8];
  logic signed [CornerW-1:0] ys_q [8];
  logic signed [47:0] pr_q [4];
  logic signed [52:0] px_q, py_q;
  logic signed [ProjW-1:0] mna_q, mxa_q, mnb_q, mxb_q;

  box_t sel;
  logic signed [31:0] hx_s, hy_s;
  logic signed [48:0] t1, t2, t3, t4, offx, offy;
  logic signed [49:0] rx, ry;
  logic signed [CornerW-1:0] cnx, cny;
  logic signed [16:0] axx, axy;
  logic signed [ProjW-1:0] p, mg;
  logic sep;

  assign sel  = k_q[2] ? box_i : mover_i;
  assign hx_s = $signed({1'b0, sel.hx});
  assign hy_s = $signed({1'b0, sel.hy});

  // offset x = sx*c*hx - sy*s*hy, offset y = sx*s*hx + sy*c*hy
  always_comb begin
    t1 = CORNER_SX_NEG[k_q[1:0]] ? -49'(pr_q[0]) : 49'(pr_q[0]);
    t2 = CORNER_SY_NEG[k_q[1:0]] ? 49'(pr_q[1]) : -49'(pr_q[1]);
    t3 = CORNER_SX_NEG[k_q[1:0]] ? -49'(pr_q[2]) : 49'(pr_q[2]);
    t4 = CORNER_SY_NEG[k_q[1:0]] ? -49'(pr_q[3]) : 49'(pr_q[3]);
    offx = t1 + t2;
    offy = t3 + t4;
    rx = 50'(offx) + 50'sd8192;
    ry = 50'(offy) + 50'sd8192;
    cnx = CornerW'(sel.cx) + rx[49:14];
    cny = CornerW'(sel.cy) + ry[49:14];
  end

  always_comb begin
    unique case (ax_q)
      2'd0: begin axx = 17'(mover_i.c);  axy = 17'(mover_i.s); end
      2'd1: begin axx = -17'(mover_i.s); axy = 17'(mover_i.c); end
      2'd2: begin axx = 17'(box_i.c);    axy = 17'(box_i.s); end
      default: begin axx = -17'(box_i.s); axy = 17'(box_i.c); end
    endcase
  end

  assign p   = ProjW'(px_q) + ProjW'(py_q);
  assign mg  = $signed({{(ProjW-30){1'b0}}, margin_i, 14'd0});
  assign sep = (mxa_q <= mnb_q + mg) || (mxb_q <= mna_q + mg);

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    sub_d     = sub_q;
    ax_d      = ax_q;
    done_o    = 1'b0;
    overlap_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CORN;
          k_d     = 3'd0;
          sub_d   = 1'b0;
        end
      end
      S_CORN: begin
        sub_d = ~sub_q;
        if (sub_q) begin
          k_d = k_q + 3'd1;
          if (k_q == 3'd7) begin
            state_d = S_PROJ;
            ax_d    = 2'd0;
          end
        end
      end
      S_PROJ: begin
        sub_d = ~sub_q;
        if (sub_q) begin
          k_d = k_q + 3'd1;
          if (k_q == 3'd7) begin
            state_d = S_CHK;
          end
        end
      end
      default: begin
        if (sep) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end else if (ax_q == 2'd3) begin
          done_o    = 1'b1;
          overlap_o = 1'b1;
          state_d   = S_IDLE;
        end else begin
          ax_d    = ax_q + 2'd1;
          k_d     = 3'd0;
          sub_d   = 1'b0;
          state_d = S_PROJ;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      sub_q   <= 1'b0;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      sub_q   <= sub_d;
      ax_q    <= ax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CORN && !sub_q) begin
      pr_q[0] <= hx_s * sel.c;
      pr_q[1] <= hy_s * sel.s;
      pr_q[2] <= hx_s * sel.s;
      pr_q[3] <= hy_s * sel.c;
    end
    if (state_q == S_CORN && sub_q) begin
      xs_q[k_q] <= cnx;
      ys_q[k_q] <= cny;
    end
    if (state_q == S_PROJ && !sub_q) begin
      px_q <= xs_q[k_q] * axx;
      py_q <= ys_q[k_q] * axy;
    end
    if (state_q == S_PROJ && sub_q) begin
      if (k_q == 3'd0) begin
        mna_q <= p;
        mxa_q <= p;
      end else if (k_q == 3'd4) begin
        mnb_q <= p;
        mxb_q <= p;
      end else if (!k_q[2]) begin
        if (p < mna_q) mna_q <= p;
        if (p > mxa_q) mxa_q <= p;
      end else begin
        if (p < mnb_q) mnb_q <= p;
        if (p > mxb_q) mxb_q <= p;
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import occ_pkg::*;

  // expected answer for one transfer on the output stream
  typedef struct {
    logic kind;
    logic blocked;
  } answer_t;

  // own model of the box table, registers and pair test
  class overlap_predictor;
    longint tab_cx[32], tab_cy[32], tab_hx[32], tab_hy[32], tab_c[32], tab_s[32];
    longint m_hx, m_hy, m_c, m_s, count, margin;
    answer_t answers_due[$];
    int mismatches;

    function new();
      m_hx = 0; m_hy = 0; m_c = 16384; m_s = 0; count = 0; margin = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_MOVER_HALF_X: m_hx = longint'(val[30:0]);
        REG_MOVER_HALF_Y: m_hy = longint'(val[30:0]);
        REG_MOVER_COS:    m_c = longint'($signed(val[15:0]));
        REG_MOVER_SIN:    m_s = longint'($signed(val[15:0]));
        REG_OBST_COUNT:   count = longint'(val[5:0]);
        REG_SEP_MARGIN:   margin = longint'(val[15:0]);
        default: ;
      endcase
    endfunction

    function void corners(longint cx, longint cy, longint hx, longint hy,
                          longint c, longint s, output longint xs[4],
                          output longint ys[4]);
      longint lx, ly;
      for (int k = 0; k < 4; k++) begin
        lx = CORNER_SX_NEG[k] ? -hx : hx;
        ly = CORNER_SY_NEG[k] ? -hy : hy;
        // q16.30 offset rounded half up to q16.16
        xs[k] = cx + ((c * lx - s * ly + 8192) >>> 14);
        ys[k] = cy + ((s * lx + c * ly + 8192) >>> 14);
      end
    endfunction

    function bit pair_overlaps(longint px, longint py, int i);
      longint axs[4], ays[4], bxs[4], bys[4];
      longint ax[4], ay[4];
      longint p, mna, mxa, mnb, mxb, gap;
      corners(px, py, m_hx, m_hy, m_c, m_s, axs, ays);
      corners(tab_cx[i], tab_cy[i], tab_hx[i], tab_hy[i], tab_c[i], tab_s[i],
              bxs, bys);
      ax[0] = m_c;       ay[0] = m_s;
      ax[1] = -m_s;      ay[1] = m_c;
      ax[2] = tab_c[i];  ay[2] = tab_s[i];
      ax[3] = -tab_s[i]; ay[3] = tab_c[i];
      gap = margin * 16384;
      for (int a = 0; a < 4; a++) begin
        for (int k = 0; k < 4; k++) begin
          p = axs[k] * ax[a] + ays[k] * ay[a];
          if (k == 0 || p < mna) mna = p;
          if (k == 0 || p > mxa) mxa = p;
          p = bxs[k] * ax[a] + bys[k] * ay[a];
          if (k == 0 || p < mnb) mnb = p;
          if (k == 0 || p > mxb) mxb = p;
        end
        if (mxa <= mnb + gap || mxb <= mna + gap) return 0;
      end
      return 1;
    endfunction

    function void note_item(logic op, logic [167:0] d);
      answer_t ans;
      int sl, n;
      longint px, py;
      sl = int'(d[4:0]);
      px = longint'($signed(d[36:5]));
      py = longint'($signed(d[68:37]));
      if (op == OP_LOAD) begin
        tab_cx[sl] = px;
        tab_cy[sl] = py;
        tab_hx[sl] = longint'(d[99:69]);
        tab_hy[sl] = longint'(d[130:100]);
        tab_c[sl] = longint'($signed(d[146:131]));
        tab_s[sl] = longint'($signed(d[162:147]));
        ans.kind = KIND_LOAD_ACK;
        ans.blocked = 1'b0;
      end else begin
        n = (count > 32) ? 32 : int'(count);
        ans.kind = KIND_QUERY;
        ans.blocked = 1'b0;
        for (int i = 0; i < n && !ans.blocked; i++)
          if (pair_overlaps(px, py, i)) ans.blocked = 1'b1;
      end
      answers_due = {answers_due, ans};
    endfunction

    function void check_answer(logic kind, logic [7:0] d);
      answer_t ans;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d tdata %h", kind, d);
        return;
      end
      ans = answers_due.pop_front();
      if (kind !== ans.kind || d !== {7'b0, ans.blocked}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind %0d blocked %0d, got kind %0d tdata %h",
                   ans.kind, ans.blocked, kind, d);
      end
    endfunction

    function int due();
      return answers_due.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [167:0]        s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tuser;

  overlap_predictor pred = new();
  bit loaded[32];
  int results_seen = 0;

  always #5 clk_i = ~clk_i;

  obb_collision_checker_core dut (.*);

  // monitor: transfers sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) pred.note_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        pred.check_answer(m_axis_tuser, m_axis_tdata);
        results_seen++;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && results_seen >= 60) begin
        held = 1;
        @(negedge clk_i) m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
      repeat (gap) @(negedge clk_i) m_axis_tready = 1'b0;
      @(negedge clk_i) m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    pred.write_reg(idx, val);
    @(negedge clk_i) cfg_we_i = 1'b0;
  endtask

  task automatic send(logic op, logic [4:0] sl, logic [31:0] px, logic [31:0] py,
                      logic [30:0] hx, logic [30:0] hy, logic [15:0] c,
                      logic [15:0] s, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    repeat (gap) @(negedge clk_i) s_axis_tvalid = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {5'b0, s, c, hy, hx, py, px, sl};
    if (op == OP_LOAD) loaded[sl] = 1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    @(negedge clk_i) s_axis_tvalid = 1'b0;
    while (pred.due() != 0) @(posedge clk_i);
  endtask

  function automatic int loaded_prefix();
    for (int i = 0; i < 32; i++) if (!loaded[i]) return i;
    return 32;
  endfunction

  // orientation of a real angle in q1.14
  function automatic logic [31:0] trig_pair();
    real a;
    logic [15:0] c, s;
    a = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
    c = 16'($rtoi(16384.0 * $cos(a)));
    s = 16'($rtoi(16384.0 * $sin(a)));
    return {s, c};
  endfunction

  function automatic logic [31:0] near_pos();
    return 32'($urandom_range(0, 40 << 16)) - 32'(20 << 16);
  endfunction

  function automatic logic [30:0] near_half();
    return 31'($urandom_range(1 << 14, 6 << 16));
  endfunction

  initial begin
    logic [31:0] tr;
    int pre, cnt, pick;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty table at reset settings
    send(OP_QUERY, 5'd0, 32'd0, 32'd0, 31'd0, 31'd0, 16'd0, 16'd0);
    drain();
    // mover half extents set; loads with extreme and special values
    write_cfg(REG_MOVER_HALF_X, 31'd4 << 16);
    write_cfg(REG_MOVER_HALF_Y, 31'd2 << 16);
    send(OP_LOAD, 5'd0, 32'd0, 32'd0, 31'd1 << 16, 31'd1 << 16, 16'sd16384, 16'sd0);
    send(OP_LOAD, 5'd1, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
         16'sd11585, 16'sd11585);
    // degenerate axis, cosine and sine both zero
    send(OP_LOAD, 5'd2, 32'd5 << 16, 32'd0, 31'd1 << 16, 31'd1 << 16, 16'd0, 16'd0);
    // out-of-range trigonometry
    send(OP_LOAD, 5'd3, 32'h80000000, 32'h7fffffff, 31'd0, 31'h7fffffff,
         16'h8000, 16'h7fff);
    send(OP_LOAD, 5'd31, 32'hffffffff, 32'd0, 31'd3 << 16, 31'd0, 16'hc000, 16'sd0);
    drain();
    write_cfg(REG_OBST_COUNT, 31'd4);
    write_cfg(REG_SEP_MARGIN, 31'd0);
    write_cfg(REG_MOVER_COS, 31'd0);
    write_cfg(REG_MOVER_SIN, 31'd16384);
    send(OP_QUERY, 5'd0, 32'd0, 32'd0, 31'd0, 31'd0, 16'd0, 16'd0);
    send(OP_QUERY, 5'd31, 32'd100 << 16, 32'd100 << 16, 31'h7fffffff, 31'h7fffffff,
         16'hffff, 16'hffff);
    send(OP_QUERY, 5'd0, 32'h7fffffff, 32'h80000000, 31'd0, 31'd0, 16'd0, 16'd0);
    send(OP_QUERY, 5'd0, 32'h80000000, 32'h7fffffff, 31'd0, 31'd0, 16'd0, 16'd0);
    drain();
    write_cfg(REG_SEP_MARGIN, 31'd65535);
    write_cfg(REG_MOVER_HALF_X, 31'h7fffffff);
    write_cfg(REG_MOVER_HALF_Y, 31'h7fffffff);
    write_cfg(REG_MOVER_COS, 31'h7fff8000);
    send(OP_QUERY, 5'd0, 32'd0, 32'd0, 31'd0, 31'd0, 16'd0, 16'd0);
    send(OP_QUERY, 5'd0, 32'd3 << 16, 32'd0, 31'd0, 31'd0, 16'd0, 16'd0);
    drain();

    // random phases
    for (int ph = 0; ph < 20; ph++) begin
      drain();
      pre = loaded_prefix();
      case (ph % 5)
        0: begin
          write_cfg(REG_MOVER_HALF_X, 31'd0);
          write_cfg(REG_MOVER_HALF_Y, 31'd0);
          write_cfg(REG_SEP_MARGIN, 31'd0);
        end
        1: begin
          write_cfg(REG_MOVER_HALF_X, 31'h7fffffff);
          write_cfg(REG_MOVER_HALF_Y, near_half());
          write_cfg(REG_SEP_MARGIN, {15'($urandom), 16'hffff});
        end
        default: begin
          write_cfg(REG_MOVER_HALF_X, near_half());
          write_cfg(REG_MOVER_HALF_Y, near_half());
          write_cfg(REG_SEP_MARGIN, 31'($urandom_range(0, 65535)));
        end
      endcase
      if (ph % 4 == 3) tr = $urandom;
      else tr = trig_pair();
      write_cfg(REG_MOVER_COS, {15'($urandom), tr[15:0]});
      write_cfg(REG_MOVER_SIN, {15'($urandom), tr[31:16]});
      // count only over loaded entries; at or above the table size once all are loaded
      if (pre == 32 && ph % 5 == 4) cnt = $urandom_range(32, 63);
      else if (ph % 5 == 4) cnt = pre;
      else cnt = $urandom_range(0, (pre < 8) ? pre : 8);
      write_cfg(REG_OBST_COUNT, {25'($urandom), 6'(cnt)});

      for (int it = 0; it < 40; it++) begin
        pick = $urandom_range(0, 9);
        tr = trig_pair();
        if (pick == 0) begin
          // noise: every field random
          send(1'($urandom), 5'($urandom), $urandom, $urandom, 31'($urandom),
               31'($urandom), 16'($urandom), 16'($urandom), ph == 2);
        end else if (pick < 5) begin
          send(OP_LOAD, ($urandom_range(0, 1) == 0 && loaded_prefix() < 32) ?
               5'(loaded_prefix()) : 5'($urandom), near_pos(), near_pos(),
               near_half(), near_half(), tr[15:0], tr[31:16], ph == 2);
        end else begin
          send(OP_QUERY, 5'($urandom), near_pos(), near_pos(), 31'($urandom),
               31'($urandom), 16'($urandom), 16'($urandom), ph == 2);
        end
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (pred.mismatches == 0 && pred.due() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/occ_pkg.sv
rtl/occ_cell.sv
rtl/occ_sat.sv
rtl/obb_collision_checker_core.sv
tb/sv/tb.sv
